// ===== design/rbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared sizes, item kind codes, control types and helper functions for the
// ring buffer deque.
// ----------------------------------------------------------------------------
package rbd_pkg;

    // Store geometry
    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths
    localparam int VALUE_W = 32;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int WIDE_W  = 64;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

    localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(DEPTH);

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;    // capture the accepted item
        logic exec;         // ring access and pointer update
        logic load_result;  // result into the output register
    } dp_cmd_t;

    // Sign-extend a 32-bit value and keep the low DATA_WIDTH bits
    function automatic logic [DATA_WIDTH-1:0] widen_value(input logic [VALUE_W-1:0] v);
        logic [WIDE_W-1:0] ext;
        begin
            ext = {{(WIDE_W - VALUE_W){v[VALUE_W-1]}}, v};
            return ext[DATA_WIDTH-1:0];
        end
    endfunction

    // Stored word zero-extended, then cut to 32 bits
    function automatic logic [VALUE_W-1:0] narrow_word(input logic [DATA_WIDTH-1:0] w);
        logic [WIDE_W-1:0] ext;
        begin
            ext = WIDE_W'(w);
            return ext[VALUE_W-1:0];
        end
    endfunction

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        begin
            return (i == IDX_LAST) ? '0 : i + 1'b1;
        end
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
        begin
            return (i == '0) ? IDX_LAST : i - 1'b1;
        end
    endfunction

endpackage

// ===== design/rbd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rbd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ctrl
// Item sequencer: capture, ring access, result hand-off.
// ----------------------------------------------------------------------------
module rbd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output rbd_pkg::dp_cmd_t cmd
);
    import rbd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // output register can take a new result
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd.load_item   = 1'b0;
        cmd.exec        = 1'b0;
        cmd.load_result = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== design/rbd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_dp
// Deque datapath: head/tail/count registers, ring store, result register.
// ----------------------------------------------------------------------------
module rbd_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rbd_pkg::dp_cmd_t                 cmd,
    input  logic [rbd_pkg::KIND_W-1:0]       kind,
    input  logic signed [rbd_pkg::VALUE_W-1:0] value,
    output logic signed [rbd_pkg::VALUE_W-1:0] popped_value,
    output logic                             was_empty,
    output logic                             matches_res,
    output logic                             overflow,
    output logic                             any_mismatch,
    output logic [rbd_pkg::COUNT_W-1:0]      fill_count
);
    import rbd_pkg::*;

    // captured item
    logic [KIND_W-1:0]  kind_reg;
    logic [VALUE_W-1:0] value_reg;

    // deque state
    logic [IDX_W-1:0]   head_reg,  head_next;
    logic [IDX_W-1:0]   tail_reg,  tail_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               mismatch_reg, mismatch_next;

    // per-item flags set during the ring access
    logic empty_reg;
    logic ovf_reg;
    logic took_reg;   // pop that removed an element

    // result register
    logic [VALUE_W-1:0] popped_reg;
    logic               was_empty_reg;
    logic               match_reg;
    logic               ovf_out_reg;
    logic [COUNT_W-1:0] fill_reg;

    logic                  is_push;
    logic                  is_front;
    logic                  empty;
    logic                  full;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [IDX_W-1:0]      ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [DATA_WIDTH-1:0] datum;
    logic                  match;

    assign is_push  = (kind_reg == KIND_PUSH_FRONT) || (kind_reg == KIND_PUSH_BACK);
    assign is_front = (kind_reg == KIND_PUSH_FRONT) || (kind_reg == KIND_POP_FRONT);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg >= COUNT_MAX);
    assign datum    = widen_value(value_reg);

    assign ram_we    = cmd.exec && is_push && !full;
    assign ram_waddr = is_front ? wrap_dec(head_reg) : wrap_inc(tail_reg);
    assign ram_raddr = is_front ? head_reg : tail_reg;

    rbd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (datum),
        .re    (cmd.exec),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // pointer and count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.exec)
        begin
            if (is_push)
            begin
                if (!full)
                begin
                    count_next = count_reg + 1'b1;
                    if (is_front)
                    begin
                        head_next = wrap_dec(head_reg);
                    end
                    else
                    begin
                        tail_next = wrap_inc(tail_reg);
                    end
                end
            end
            else if (!empty)
            begin
                count_next = count_reg - 1'b1;
                if (is_front)
                begin
                    head_next = wrap_inc(head_reg);
                end
                else
                begin
                    tail_next = wrap_dec(tail_reg);
                end
            end
        end
    end

    // check of the popped element, read data valid in the result cycle
    always_comb
    begin
        if (is_push)
        begin
            match = 1'b1;
        end
        else if (took_reg)
        begin
            match = (ram_rdata == datum);
        end
        else
        begin
            match = (value_reg == '1);
        end
        mismatch_next = mismatch_reg;
        if (cmd.load_result && !match)
        begin
            mismatch_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= IDX_LAST;
            count_reg    <= '0;
            mismatch_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            mismatch_reg <= mismatch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg  <= kind;
            value_reg <= value;
        end
        if (cmd.exec)
        begin
            empty_reg <= empty;
            ovf_reg   <= is_push && full;
            took_reg  <= !is_push && !empty;
        end
        if (cmd.load_result)
        begin
            popped_reg    <= took_reg ? narrow_word(ram_rdata) : '0;
            was_empty_reg <= empty_reg;
            match_reg     <= match;
            ovf_out_reg   <= ovf_reg;
            fill_reg      <= count_reg;
        end
    end

    assign popped_value = popped_reg;
    assign was_empty    = was_empty_reg;
    assign matches_res  = match_reg;
    assign overflow     = ovf_out_reg;
    assign any_mismatch = mismatch_reg;
    assign fill_count   = fill_reg;

endmodule

// ===== design/ring_buffer_deque.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue in a ring store, with checked pops and a sticky
// mismatch flag.
// ----------------------------------------------------------------------------
// Each item is a push or pop at the front or back. A push to a full store is
// dropped and flagged in overflow; a pop from an empty store changes nothing
// and matches only when value is -1. A pop compares the removed element with
// value and sets the sticky any_mismatch flag on a failure. Each item goes
// through capture, one access to the ring RAM, whose one write port and one
// read port serve both ends (write for a push, registered read for a pop),
// then the check and load of the output register. The next item is taken
// once the previous result sits in the output register, even if the
// downstream side has not yet taken it; a stall on the output holds the
// block only when a second result is ready. The ring store has no reset
// and needs no clearing pass: a pop only ever reads entries a push has
// written. After reset the deque is empty, ready for items at once.
// ----------------------------------------------------------------------------
module ring_buffer_deque (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rbd_pkg::KIND_W-1:0]         kind,
    input  logic signed [rbd_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [rbd_pkg::VALUE_W-1:0] popped_value,
    output logic                               was_empty,
    output logic                               matches_res,
    output logic                               overflow,
    output logic                               any_mismatch,
    output logic [rbd_pkg::COUNT_W-1:0]        fill_count
);
    import rbd_pkg::*;

    dp_cmd_t cmd;

    // sequencer: owns both handshakes
    rbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // pointers, ring store and result register
    rbd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .kind         (kind),
        .value        (value),
        .popped_value (popped_value),
        .was_empty    (was_empty),
        .matches_res  (matches_res),
        .overflow     (overflow),
        .any_mismatch (any_mismatch),
        .fill_count   (fill_count)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ring_buffer_deque.
// ----------------------------------------------------------------------------
// A queue of planned items, built up front, feeds a valid/ready driver. Every
// accepted item goes through a bench-side deque model that predicts its
// result. A monitor checks each accepted result against the oldest prediction.
// Stimulus order: a directed opening (empty pops, index wrap on both ends,
// extreme data, -1 stored and expected, mismatches on empty and non-empty
// pops), then random mixes and a drain that ends with pops when empty.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import rbd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS = 10;

    // One planned input item; hold_for_drain stalls the sender until every
    // outstanding result has come back.
    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        bit                 hold_for_drain;
    } planned_op_t;

    // Expected result of one item, laid out in port order
    typedef struct packed {
        logic [VALUE_W-1:0] popped;
        logic               was_empty;
        logic               matched;
        logic               ovf;
        logic               sticky;
        logic [COUNT_W-1:0] fill;
    } deque_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [KIND_W-1:0]         kind = KIND_PUSH_BACK;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [VALUE_W-1:0] popped_value;
    logic                      was_empty;
    logic                      matches_res;
    logic                      overflow;
    logic                      any_mismatch;
    logic [COUNT_W-1:0]        fill_count;

    ring_buffer_deque DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .popped_value (popped_value),
        .was_empty    (was_empty),
        .matches_res  (matches_res),
        .overflow     (overflow),
        .any_mismatch (any_mismatch),
        .fill_count   (fill_count)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench-side deque model
    // ------------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] ring_copy [DEPTH];
    logic [IDX_W-1:0]      front_idx  = '0;
    logic [IDX_W-1:0]      back_idx   = IDX_W'(DEPTH - 1);
    logic [COUNT_W-1:0]    held_count = '0;
    logic                  miss_flag  = 1'b0;

    planned_op_t   op_queue[$];          // items still to be driven
    deque_result_t pending_results[$];   // predictions awaiting their result
    logic [VALUE_W-1:0] gen_contents[$]; // planner's view of the deque

    int unsigned cycle_count = 0;
    int          fail_count = 0;
    logic        in_taken = 1'b0;
    int          idle_left = 0;
    int          stall_left = 0;
    bit          in_calm = 1'b0;
    bit          out_calm = 1'b0;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    // Applies one item to the model and returns the result it must produce
    function automatic deque_result_t next_deque_result(input logic [KIND_W-1:0] k,
                                                        input logic [VALUE_W-1:0] v);
        deque_result_t r;
        logic [63:0] ext;
        logic [DATA_WIDTH-1:0] datum;
        logic [DATA_WIDTH-1:0] word;
        ext = {{(64 - VALUE_W){v[VALUE_W-1]}}, v};
        datum = ext[DATA_WIDTH-1:0];
        r = '0;
        r.matched = 1'b1;
        r.was_empty = (held_count == '0);
        case (k)
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                if (held_count == COUNT_MAX)
                begin
                    r.ovf = 1'b1;   // full: drop the datum
                end
                else
                begin
                    if (k == KIND_PUSH_FRONT)
                    begin
                        front_idx = ring_prev(front_idx);
                        ring_copy[front_idx] = datum;
                    end
                    else
                    begin
                        back_idx = ring_next(back_idx);
                        ring_copy[back_idx] = datum;
                    end
                    held_count = held_count + 1'b1;
                end
            end
            default:
            begin
                if (held_count == '0)
                begin
                    r.matched = (v == '1);   // only -1 expects empty
                end
                else
                begin
                    word = (k == KIND_POP_FRONT) ? ring_copy[front_idx] : ring_copy[back_idx];
                    ext = '0;
                    ext[DATA_WIDTH-1:0] = word;
                    r.popped = ext[VALUE_W-1:0];
                    r.matched = (word == datum);
                    if (k == KIND_POP_FRONT)
                        front_idx = ring_next(front_idx);
                    else
                        back_idx = ring_prev(back_idx);
                    held_count = held_count - 1'b1;
                end
                if (!r.matched)
                    miss_flag = 1'b1;
            end
        endcase
        r.sticky = miss_flag;
        r.fill = held_count;
        return r;
    endfunction

    function automatic string fmt_result(input deque_result_t r);
        return $sformatf("popped=%h empty=%b match=%b ovf=%b sticky=%b fill=%0d",
                         r.popped, r.was_empty, r.matched, r.ovf, r.sticky, r.fill);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Planning: keeps a shadow of the contents so pops can carry the right
    // expectation most of the time
    // ------------------------------------------------------------------------
    task automatic plan_op(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
                           input bit hold);
        planned_op_t op;
        case (k)
            KIND_PUSH_FRONT: if (gen_contents.size() < DEPTH) gen_contents.insert(0, v);
            KIND_PUSH_BACK:
                if (gen_contents.size() < DEPTH)
                    gen_contents.insert(gen_contents.size(), v);
            KIND_POP_FRONT:  if (gen_contents.size() != 0) gen_contents.delete(0);
            default:
                if (gen_contents.size() != 0)
                    gen_contents.delete(gen_contents.size() - 1);
        endcase
        op.kind = k;
        op.value = v;
        op.hold_for_drain = hold;
        op_queue.insert(op_queue.size(), op);
    endtask

    task automatic plan_random_op(input int push_pct, input bit hold);
        logic [KIND_W-1:0]  k;
        logic [VALUE_W-1:0] v;
        bit front;
        int r;
        front = $urandom_range(0, 1);
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < push_pct)
        begin
            k = front ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
            case ($urandom_range(0, 15))
                0:       v = '0;
                1:       v = '1;
                2:       v = 32'h7FFF_FFFF;
                3:       v = 32'h8000_0000;
                default: v = $urandom();
            endcase
        end
        else
        begin
            k = front ? KIND_POP_FRONT : KIND_POP_BACK;
            if (gen_contents.size() == 0)
                v = (r < 80) ? '1 : $urandom();
            else if (r < 75)
                v = front ? gen_contents[0] : gen_contents[$];
            else if (r < 85)
                v = '1;
            else
                v = $urandom();
        end
        plan_op(k, v, hold || ($urandom_range(0, 99) == 0));
    endtask

    // ------------------------------------------------------------------------
    // Input driver: changes on the falling edge, holds until accepted
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_items
        planned_op_t op;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (idle_left != 0)
            begin
                in_valid <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (op_queue.size() != 0 &&
                     !(op_queue[0].hold_for_drain && pending_results.size() != 0))
            begin
                op = op_queue[0];
                op_queue.delete(0);
                kind <= op.kind;
                value <= op.value;
                in_valid <= 1'b1;
                idle_left <= in_calm ? 0 : pick_gap();
                if ($urandom_range(0, 99) == 0)
                    in_calm <= !in_calm;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure, with calm stretches of no stalls
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!out_calm && $urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= pick_gap();
        end
        else
        begin
            out_ready <= 1'b1;
        end
        if ($urandom_range(0, 199) == 0)
            out_calm <= !out_calm;
    end

    // ------------------------------------------------------------------------
    // Monitor: checks results, predicts accepted items, guards the run time
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        deque_result_t want;
        deque_result_t got;
        cycle_count++;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                got = '{popped_value, was_empty, matches_res, overflow, any_mismatch,
                        fill_count};
                if (pending_results.size() == 0)
                begin
                    note_failure($sformatf("unexpected result: %s", fmt_result(got)));
                end
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (got !== want)
                        note_failure($sformatf("expected %s, got %s",
                                               fmt_result(want), fmt_result(got)));
                end
            end
            // A result never belongs to the item taken at the same edge
            if (in_valid && in_ready)
                pending_results.insert(pending_results.size(),
                                       next_deque_result(kind, value));
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        // Directed opening; head wraps below 0 and tail wraps past DEPTH-1
        plan_op(KIND_POP_FRONT,  '1,           1'b0);  // empty, expects empty
        plan_op(KIND_POP_BACK,   '1,           1'b0);
        plan_op(KIND_PUSH_BACK,  32'h7FFF_FFFF, 1'b0);
        plan_op(KIND_PUSH_FRONT, 32'h8000_0000, 1'b0);
        plan_op(KIND_PUSH_BACK,  '1,           1'b0);  // -1 stored as data
        plan_op(KIND_PUSH_FRONT, '0,           1'b0);
        plan_op(KIND_PUSH_FRONT, 32'd1,        1'b0);
        plan_op(KIND_POP_FRONT,  32'd1,        1'b0);
        plan_op(KIND_POP_BACK,   '1,           1'b0);  // stored -1 meets expected -1
        plan_op(KIND_POP_FRONT,  '0,           1'b0);
        plan_op(KIND_POP_BACK,   32'h7FFF_FFFF, 1'b0);
        plan_op(KIND_POP_FRONT,  32'h8000_0000, 1'b0);  // back to empty
        plan_op(KIND_PUSH_BACK,  32'h1234_5678, 1'b0);
        plan_op(KIND_POP_BACK,   32'h1234_5678, 1'b0);
        plan_op(KIND_PUSH_FRONT, 32'h55AA_55AA, 1'b0);
        plan_op(KIND_POP_BACK,   '0,           1'b0);  // wrong value, non-empty
        plan_op(KIND_POP_FRONT,  '0,           1'b0);  // wrong value, empty
        plan_op(KIND_POP_BACK,   '1,           1'b0);
        plan_op(KIND_PUSH_BACK,  32'hA5A5_A5A5, 1'b0);
        plan_op(KIND_POP_FRONT,  32'hA5A5_A5A5, 1'b0);

        // Random mixes with a drifting push/pop balance
        repeat (13)
        begin
            automatic int pct = $urandom_range(25, 75);
            repeat (50)
                plan_random_op(pct, 1'b0);
        end

        // Drain with the sender held until all results are back, then pop
        // when empty
        plan_random_op(0, 1'b1);
        while (gen_contents.size() != 0)
            plan_random_op(0, 1'b0);
        repeat (3)
            plan_random_op(0, 1'b0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
design/rbd_pkg.sv
design/rbd_ram.sv
design/rbd_ctrl.sv
design/rbd_dp.sv
design/ring_buffer_deque.sv
verif/tb.sv
